// File: rtl/uvsq_pkg.sv
package uvsq_pkg;

  localparam int SINE_DEPTH  = 256;
  localparam int SINE_IDX_W  = $clog2(SINE_DEPTH + 1);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int LON_W = 9;
  localparam int LAT_W = 8;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_RADIUS   = 3'd3;
  localparam logic [2:0] REG_STEP     = 3'd4;
  localparam logic [2:0] REG_COLOR    = 3'd5;

  typedef logic [14:0] sine_tab_t [0:SINE_DEPTH];

  // one vertex to compute
  typedef struct packed {
    logic             valid;
    logic [LON_W-1:0] lon;
    logic [LAT_W-1:0] lat;
    logic             last;
  } vtx_req_t;

  // trig values of one vertex plus side payload
  typedef struct packed {
    logic               valid;
    logic signed [15:0] sin_lat;
    logic signed [15:0] cos_lat;
    logic signed [15:0] sin_lon;
    logic signed [15:0] cos_lon;
    logic [16:0]        u;
    logic [17:0]        v;
    logic               last;
  } vtx_trig_t;

  // quarter-wave table, integer taylor series in q30, rounded to q1.14
  function automatic sine_tab_t build_sine();
    sine_tab_t          t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x = (64'(i) * HALF_PI_Q30) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      q = (sum + 64'sd32768) >>> 16;
      if (q > 64'sd16384) q = 64'sd16384;
      t[i] = q[14:0];
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic logic signed [15:0] sin_q14(input logic [15:0] ph);
    logic [1:0]                  quad;
    logic [13:0]                 frac;
    logic [14+SINE_IDX_W:0]      prod;
    logic [SINE_IDX_W:0]         pf;
    logic [14:0]                 val;
    quad = ph[15:14];
    frac = ph[13:0];
    prod = (($bits(prod))'(frac) * ($bits(prod))'(SINE_DEPTH)) + ($bits(prod))'(8192);
    pf = prod[14+SINE_IDX_W:14];
    if (pf > ($bits(pf))'(SINE_DEPTH)) pf = ($bits(pf))'(SINE_DEPTH);
    if (quad[0]) pf = ($bits(pf))'(SINE_DEPTH) - pf;
    val = SINE_TAB[pf[SINE_IDX_W-1:0]];
    return quad[1] ? -$signed({1'b0, val}) : $signed({1'b0, val});
  endfunction

  // round to nearest, ties away from zero, then drop 14 bits
  function automatic logic signed [33:0] round_q14(input logic signed [47:0] a);
    logic [47:0] mag;
    logic [47:0] r;
    mag = a[47] ? 48'(-a) : 48'(a);
    r = (mag + 48'd8192) >> 14;
    return a[47] ? -$signed(r[33:0]) : $signed(r[33:0]);
  endfunction

endpackage

// File: rtl/uvsq_seq.sv
module uvsq_seq
  import uvsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] longitude_index,
  input  logic [6:0] latitude_index,
  output logic       busy,
  output vtx_req_t   req
);

  logic       active;
  logic [1:0] idx;
  logic [7:0] lon;
  logic [6:0] lat;
  logic       take;

  assign busy = active && (idx != 2'd3);
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx <= 2'd0;
    end else if (take) begin
      active <= 1'b1;
      idx <= 2'd0;
    end else if (active) begin
      idx <= idx + 2'd1;
      if (idx == 2'd3) active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lon <= longitude_index;
      lat <= latitude_index;
    end
  end

  // corner order: (lon,lat+1) (lon+1,lat+1) (lon+1,lat) (lon,lat)
  always_comb begin
    req.valid = active;
    req.last = (idx == 2'd3);
    req.lon = (idx == 2'd1 || idx == 2'd2) ? LON_W'(lon) + LON_W'(1) : LON_W'(lon);
    req.lat = (idx == 2'd0 || idx == 2'd1) ? LAT_W'(lat) + LAT_W'(1) : LAT_W'(lat);
  end

endmodule

// File: rtl/uvsq_angle.sv
module uvsq_angle
  import uvsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [16:0] step,
  input  vtx_req_t    req,
  output vtx_trig_t   trig
);

  logic        s1_valid;
  logic [15:0] s1_lon_ph;
  logic [15:0] s1_lat_ph;
  logic [16:0] s1_u;
  logic [17:0] s1_v;
  logic        s1_last;
  logic [25:0] lon_prod;
  logic [25:0] lat_prod;

  assign lon_prod = 26'(req.lon) * 26'(step);
  assign lat_prod = 26'(req.lat) * 26'(step);

  // stage 1: phases and texture coordinates
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= req.valid;
  end

  always_ff @(posedge clk) begin
    s1_lon_ph <= lon_prod[15:0];
    s1_lat_ph <= lat_prod[15:0];
    s1_u <= (lon_prod > 26'd65536) ? 17'd65536 : lon_prod[16:0];
    s1_v <= ({lat_prod, 1'b0} > 27'd131072) ? 18'd131072 : {lat_prod[16:0], 1'b0};
    s1_last <= req.last;
  end

  // stage 2: table lookups
  always_ff @(posedge clk) begin
    if (rst) trig.valid <= 1'b0;
    else trig.valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    trig.sin_lat <= sin_q14(s1_lat_ph);
    trig.cos_lat <= sin_q14(s1_lat_ph + 16'd16384);
    trig.sin_lon <= sin_q14(s1_lon_ph);
    trig.cos_lon <= sin_q14(s1_lon_ph + 16'd16384);
    trig.u <= s1_u;
    trig.v <= s1_v;
    trig.last <= s1_last;
  end

endmodule

// File: rtl/uvsq_geom.sv
module uvsq_geom
  import uvsq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        radius,
  input  logic [31:0]        color,
  input  vtx_trig_t          trig,
  output logic               vertex_valid,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [16:0]        tex_u,
  output logic [17:0]        tex_v,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic signed [15:0] tangent_x,
  output logic signed [15:0] tangent_z,
  output logic [31:0]        color_out,
  output logic               last_vertex
);

  // stage 3: direction
  logic               s3_valid;
  logic signed [15:0] s3_dx;
  logic signed [15:0] s3_dy;
  logic signed [15:0] s3_dz;
  logic [16:0]        s3_u;
  logic [17:0]        s3_v;
  logic               s3_last;
  logic signed [33:0] dx_r;
  logic signed [33:0] dz_r;

  assign dx_r = round_q14(48'(trig.cos_lon) * 48'(trig.sin_lat));
  assign dz_r = round_q14(48'(trig.sin_lon) * 48'(trig.sin_lat));

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else s3_valid <= trig.valid;
  end

  always_ff @(posedge clk) begin
    s3_dx <= dx_r[15:0];
    s3_dy <= trig.cos_lat;
    s3_dz <= dz_r[15:0];
    s3_u <= trig.u;
    s3_v <= trig.v;
    s3_last <= trig.last;
  end

  // stage 4: offsets scaled by radius
  logic               s4_valid;
  logic signed [33:0] s4_ox;
  logic signed [33:0] s4_oy;
  logic signed [33:0] s4_oz;
  logic signed [15:0] s4_dx;
  logic signed [15:0] s4_dy;
  logic signed [15:0] s4_dz;
  logic [16:0]        s4_u;
  logic [17:0]        s4_v;
  logic               s4_last;
  logic signed [31:0] rad_s;

  assign rad_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else s4_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    s4_ox <= round_q14(48'(s3_dx) * 48'(rad_s));
    s4_oy <= round_q14(48'(s3_dy) * 48'(rad_s));
    s4_oz <= round_q14(48'(s3_dz) * 48'(rad_s));
    s4_dx <= s3_dx;
    s4_dy <= s3_dy;
    s4_dz <= s3_dz;
    s4_u <= s3_u;
    s4_v <= s3_v;
    s4_last <= s3_last;
  end

  // stage 5: add center with saturation
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] c,
                                                 input logic signed [33:0] o);
    logic signed [34:0] s;
    s = 35'(c) + 35'(o);
    if (s > 35'sd2147483647) return 32'sh7fffffff;
    if (s < -35'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vertex_valid <= 1'b0;
    else vertex_valid <= s4_valid;
  end

  always_ff @(posedge clk) begin
    pos_x <= sat_add(center_x, s4_ox);
    pos_y <= sat_add(center_y, s4_oy);
    pos_z <= sat_add(center_z, s4_oz);
    tex_u <= s4_u;
    tex_v <= s4_v;
    normal_x <= s4_dx;
    normal_y <= s4_dy;
    normal_z <= s4_dz;
    tangent_x <= s4_dz;
    tangent_z <= -s4_dx;
    color_out <= color;
    last_vertex <= s4_last;
  end

endmodule

// File: rtl/uv_sphere_quad_vertex_generator_core.sv
// channel   | direction | handshake        | payload
// request   | in        | start / busy     | longitude_index, latitude_index
// vertex    | out       | vertex_valid     | pos, tex, normal, tangent, color, last
// config    | in        | cfg_we           | cfg_addr, cfg_wdata
//
// each request yields four vertices on consecutive cycles
// a new request is taken on the cycle the previous one issues its last
// vertex, so quads stream back to back
// the first vertex strobe rises once the request has passed the five
// register stages behind the corner sequencer
// rst is synchronous and clears the sequencer state, valid bits and config registers
// the vertex side cannot stall; busy only reflects the corner sequencer
module uv_sphere_quad_vertex_generator_core
  import uvsq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         longitude_index,
  input  logic [6:0]         latitude_index,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  output logic               vertex_valid,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [16:0]        tex_u,
  output logic [17:0]        tex_v,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic signed [15:0] tangent_x,
  output logic signed [15:0] tangent_z,
  output logic [31:0]        color_out,
  output logic               last_vertex
);

  // configuration registers
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        sphere_radius;
  logic [16:0]        angle_step;
  logic [31:0]        vertex_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      sphere_radius <= 31'd65536;
      angle_step <= 17'd4096;
      vertex_color <= 32'hffffffff;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CENTER_X: center_x <= cfg_wdata;
        REG_CENTER_Y: center_y <= cfg_wdata;
        REG_CENTER_Z: center_z <= cfg_wdata;
        REG_RADIUS:   sphere_radius <= cfg_wdata[30:0];
        REG_STEP:     angle_step <= cfg_wdata[16:0];
        REG_COLOR:    vertex_color <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vtx_req_t  req;
  vtx_trig_t trig;

  // corner sequencer: one vertex per cycle
  uvsq_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .longitude_index (longitude_index),
    .latitude_index  (latitude_index),
    .busy            (busy),
    .req             (req)
  );

  // phases, texture coordinates, sine table lookups
  uvsq_angle u_angle (
    .clk  (clk),
    .rst  (rst),
    .step (angle_step),
    .req  (req),
    .trig (trig)
  );

  // direction, radius scaling, center add
  uvsq_geom u_geom (
    .clk          (clk),
    .rst          (rst),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_z     (center_z),
    .radius       (sphere_radius),
    .color        (vertex_color),
    .trig         (trig),
    .vertex_valid (vertex_valid),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .tangent_x    (tangent_x),
    .tangent_z    (tangent_z),
    .color_out    (color_out),
    .last_vertex  (last_vertex)
  );

endmodule
